// ===== rtl/core/dghc_pkg.sv =====
// Shared types, constants and helpers for the datagram header checker/framer.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package dghc_pkg;

    // Sizing
    localparam int MASTER_COUNT = 4;     // masters in use (1..4)
    localparam int SLOT_COUNT   = 4;     // session/sequence register slots
    localparam int SLOT_W       = 2;     // bits to pick a slot
    localparam int MAX_PAYLOAD  = 1024;  // largest payload a transmit may announce
    localparam int HDR_LEN      = 24;    // header bytes
    localparam int COUNT_W      = 17;    // saturating byte counter width
    localparam int IDX_W        = 5;     // header offset counter width
    localparam int REG_IDX_W    = 3;     // config register index width

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Header field codes
    localparam logic [7:0] VERSION_CODE  = 8'd1;
    localparam logic [7:0] KIND_OUT_CODE = 8'd1;
    localparam logic [7:0] KIND_IN_CODE  = 8'd2;

    // Input command codes
    localparam logic CMD_RX = 1'b0;
    localparam logic CMD_TX = 1'b1;

    // Config register indexes (0..3 are the per-master session ids)
    localparam logic [REG_IDX_W-1:0] REG_SESSION_LAST = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OPEN_MASK    = 3'd4;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_VERDICT   = 2'd0,
        KIND_TX_BYTE   = 2'd1,
        KIND_TX_REFUSE = 2'd2
    } res_kind_t;

    typedef logic [SLOT_COUNT-1:0][63:0] sess_arr_t;

    // Receive verdict for the byte being consumed
    typedef struct packed {
        logic        accepted;
        logic [7:0]  master;
        logic [7:0]  flags;
        logic [15:0] length;
    } verdict_t;

    // Transmit framer status for the current header offset
    typedef struct packed {
        logic       refused;
        logic       last;
        logic [7:0] data;
    } tx_out_t;

    // Magic letters E D O G at offsets 0..3
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h45;
            2'd1:    b = 8'h44;
            2'd2:    b = 8'h4F;
            default: b = 8'h47;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dghc_rx_check.sv =====
// Receive header checker: streams datagram bytes, tracks the header and forms the verdict.
// Depends on dghc_pkg.
`default_nettype none

module dghc_rx_check
    import dghc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           rx_end,
    input  wire sess_arr_t      session,
    input  wire logic [3:0]     open_mask,
    output verdict_t            verdict
);

    logic [COUNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic               hok_reg, hok_next;
    logic [7:0]         master_reg, master_next;
    logic [7:0]         flags_reg, flags_next;
    logic [15:0]        len_reg, len_next;
    logic [4:0]         off;
    logic [63:0]        sess_word;
    logic [7:0]         sess_byte;
    logic               usable;
    logic               ok;

    assign off       = cnt_reg[4:0];
    assign sess_word = session[master_reg[SLOT_W-1:0]];
    assign sess_byte = 8'(sess_word >> {off[2:0], 3'b000});
    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // Header field checks and captures for this byte
    always_comb
    begin
        hok_next    = hok_reg;
        master_next = master_reg;
        flags_next  = flags_reg;
        len_next    = len_reg;
        if (cnt_reg < COUNT_W'(HDR_LEN))
        begin
            case (off)
                5'd0, 5'd1, 5'd2, 5'd3:
                    if (rx_byte != magic_byte(off[1:0])) hok_next = 1'b0;
                5'd4:
                    if (rx_byte != VERSION_CODE) hok_next = 1'b0;
                5'd5:
                    if (rx_byte != KIND_IN_CODE) hok_next = 1'b0;
                5'd6:
                    master_next = rx_byte;
                5'd7:
                    flags_next = rx_byte;
                5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
                    if (master_reg >= 8'(MASTER_COUNT) || rx_byte != sess_byte)
                        hok_next = 1'b0;
                5'd20:
                    len_next = {len_reg[15:8], rx_byte};
                5'd21:
                    len_next = {rx_byte, len_reg[7:0]};
                default:
                    ;
            endcase
        end
    end

    // Verdict on the final byte; open mask is sampled here
    assign usable = (master_next < 8'(MASTER_COUNT)) && open_mask[master_next[SLOT_W-1:0]];
    assign ok     = (cnt_inc >= COUNT_W'(HDR_LEN)) && hok_next && usable
                    && (cnt_inc == COUNT_W'(HDR_LEN) + COUNT_W'(len_next));

    always_comb
    begin
        verdict.accepted = ok;
        verdict.master   = ok ? master_next : 8'd0;
        verdict.flags    = ok ? flags_next  : 8'd0;
        verdict.length   = ok ? len_next    : 16'd0;
    end

    // Datagram state; any verdict restarts it
    always_comb
    begin
        cnt_next = cnt_inc;
        if (rx_end)
            cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            hok_reg    <= 1'b1;
            master_reg <= '0;
            flags_reg  <= '0;
            len_reg    <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_next;
            if (rx_end)
            begin
                hok_reg    <= 1'b1;
                master_reg <= '0;
                flags_reg  <= '0;
                len_reg    <= '0;
            end
            else
            begin
                hok_reg    <= hok_next;
                master_reg <= master_next;
                flags_reg  <= flags_next;
                len_reg    <= len_next;
            end
        end
    end

    // Checks
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && rx_end |=> cnt_reg == '0 && hok_reg && len_reg == '0)
        else $error("receive state not cleared after verdict");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        step && !rx_end && cnt_reg != COUNT_MAX |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("byte count did not advance");

    a_accept_master: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.accepted |-> master_next < 8'(MASTER_COUNT) && cnt_inc >= COUNT_W'(HDR_LEN))
        else $error("accepted verdict with bad master or short datagram");

endmodule

`default_nettype wire

// ===== rtl/core/dghc_tx_frame.sv =====
// Transmit header framer: walks header offsets 0..23 and owns the per-master sequences.
// Depends on dghc_pkg.
`default_nettype none

module dghc_tx_frame
    import dghc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [SLOT_COUNT-1:0] seq_clr,
    input  wire logic [7:0]            tx_master,
    input  wire logic [15:0]           tx_length,
    input  wire logic                  tx_valid,
    input  wire sess_arr_t             session,
    input  wire logic [3:0]            open_mask,
    output tx_out_t                    tx_out
);

    logic [IDX_W-1:0]               idx_reg;
    logic [SLOT_COUNT-1:0][31:0]    seq_reg;
    logic [SLOT_W-1:0]              slot;
    logic [31:0]                    seq_cur;
    logic [63:0]                    sess_word;
    logic                           refused;
    logic                           last;
    logic [7:0]                     data;

    assign slot      = tx_master[SLOT_W-1:0];
    assign seq_cur   = seq_reg[slot];
    assign sess_word = session[slot];
    assign refused   = (tx_master >= 8'(MASTER_COUNT)) || !open_mask[slot]
                       || (tx_length > 16'(MAX_PAYLOAD));
    assign last      = refused || (idx_reg == IDX_W'(HDR_LEN - 1));

    // Header byte at the current offset
    always_comb
    begin
        case (idx_reg)
            5'd0, 5'd1, 5'd2, 5'd3:
                data = magic_byte(idx_reg[1:0]);
            5'd4:
                data = VERSION_CODE;
            5'd5:
                data = KIND_OUT_CODE;
            5'd6:
                data = tx_master;
            5'd7:
                data = {7'd0, tx_valid};
            5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
                data = 8'(sess_word >> {idx_reg[2:0], 3'b000});
            5'd16, 5'd17, 5'd18, 5'd19:
                data = 8'(seq_cur >> {idx_reg[1:0], 3'b000});
            5'd20:
                data = tx_length[7:0];
            5'd21:
                data = tx_length[15:8];
            default:
                data = 8'd0;
        endcase
    end

    always_comb
    begin
        tx_out.refused = refused;
        tx_out.last    = last;
        tx_out.data    = data;
    end

    // Offset counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (step)
            idx_reg <= last ? '0 : idx_reg + 1'b1;
    end

    // Sequences: bumped on the first byte of a frame, cleared by a session write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= '0;
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (seq_clr[i])
                    seq_reg[i] <= '0;
                else if (step && !refused && idx_reg == '0 && slot == SLOT_W'(i))
                    seq_reg[i] <= seq_reg[i] + 1'b1;
            end
        end
    end

    // Checks
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < IDX_W'(HDR_LEN))
        else $error("header offset out of range");

    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> idx_reg == '0)
        else $error("offset not reset after last byte");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last |=> idx_reg == $past(idx_reg) + 1'b1)
        else $error("offset did not advance");

endmodule

`default_nettype wire

// ===== rtl/core/datagram_header_check_and_frame_top.sv =====
// Top level: config registers, input stage, output register; joins checker and framer.
// Depends on dghc_pkg, dghc_rx_check, dghc_tx_frame.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------------
//  in      | in_valid/in_ready  | cmd, rx_byte, rx_end, tx_master, tx_length, tx_valid
//  out     | out_valid/out_ready| kind, accepted, rx_master, rx_flags, rx_payload_len,
//          |                    | tx_byte, tx_end
//  cfg     | cfg_wr_en          | cfg_index, cfg_data (no read-back)
//
// Received bytes stream at one per cycle, but a byte with rx_end waits for a free output register.
// A transmit request holds the input stage while it yields one result per header byte, or a
// single refusal result if refused; the output register then sets the pace.
// Each result is registered at the edge that consumes it, so the first result of an item
// follows its input transfer via the input stage register, then the output register.
// Reset clears config, sequences and receive state; no clearing pass is needed.
// A stalled output only stalls items that produce a result; bytes before rx_end pass.
`default_nettype none

module datagram_header_check_and_frame_top
    import dghc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 cmd,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 rx_end,
    input  wire logic [7:0]           tx_master,
    input  wire logic [15:0]          tx_length,
    input  wire logic                 tx_valid,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                kind,
    output logic                      accepted,
    output logic [7:0]                rx_master,
    output logic [7:0]                rx_flags,
    output logic [15:0]               rx_payload_len,
    output logic [7:0]                tx_byte,
    output logic                      tx_end
);

    // Config registers
    sess_arr_t              sess_reg;
    logic [3:0]             open_reg;
    logic [SLOT_COUNT-1:0]  seq_clr;

    // Input stage
    logic        hold_valid_reg;
    logic        cmd_reg;
    logic [7:0]  rx_byte_reg;
    logic        rx_end_reg;
    logic [7:0]  tx_master_reg;
    logic [15:0] tx_length_reg;
    logic        tx_valid_reg;

    // Output register
    logic        out_valid_reg;
    res_kind_t   kind_reg, kind_next;
    logic        accepted_reg, accepted_next;
    logic [7:0]  rx_master_reg, rx_master_next;
    logic [7:0]  rx_flags_reg, rx_flags_next;
    logic [15:0] rx_len_reg, rx_len_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_end_reg, tx_end_next;

    // Control
    logic        out_free;
    logic        is_rx;
    logic        rx_step;
    logic        tx_step;
    logic        hold_done;
    logic        out_load;
    verdict_t    verdict;
    tx_out_t     tx_out;

    // Config writes; a session write also clears that master's sequence
    always_comb
    begin
        seq_clr = '0;
        if (cfg_wr_en && cfg_index <= REG_SESSION_LAST)
            seq_clr[cfg_index[SLOT_W-1:0]] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_reg <= '0;
            open_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index <= REG_SESSION_LAST)
                sess_reg[cfg_index[SLOT_W-1:0]] <= cfg_data;
            else if (cfg_index == REG_OPEN_MASK)
                open_reg <= cfg_data[3:0];
        end
    end

    // Stage control
    assign out_free  = !out_valid_reg || out_ready;
    assign is_rx     = (cmd_reg == CMD_RX);
    assign rx_step   = hold_valid_reg && is_rx && (!rx_end_reg || out_free);
    assign tx_step   = hold_valid_reg && !is_rx && out_free;
    assign hold_done = rx_step || (tx_step && tx_out.last);
    assign out_load  = (rx_step && rx_end_reg) || tx_step;
    assign in_ready  = !hold_valid_reg || hold_done;

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            hold_valid_reg <= 1'b1;
        else if (hold_done)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg       <= cmd;
            rx_byte_reg   <= rx_byte;
            rx_end_reg    <= rx_end;
            tx_master_reg <= tx_master;
            tx_length_reg <= tx_length;
            tx_valid_reg  <= tx_valid;
        end
    end

    dghc_rx_check u_rx_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (rx_step),
        .rx_byte   (rx_byte_reg),
        .rx_end    (rx_end_reg),
        .session   (sess_reg),
        .open_mask (open_reg),
        .verdict   (verdict)
    );

    dghc_tx_frame u_tx_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (tx_step),
        .seq_clr   (seq_clr),
        .tx_master (tx_master_reg),
        .tx_length (tx_length_reg),
        .tx_valid  (tx_valid_reg),
        .session   (sess_reg),
        .open_mask (open_reg),
        .tx_out    (tx_out)
    );

    // Result formatting; fields outside the kind stay zero
    always_comb
    begin
        kind_next      = KIND_VERDICT;
        accepted_next  = 1'b0;
        rx_master_next = '0;
        rx_flags_next  = '0;
        rx_len_next    = '0;
        tx_byte_next   = '0;
        tx_end_next    = 1'b0;
        if (is_rx)
        begin
            accepted_next  = verdict.accepted;
            rx_master_next = verdict.master;
            rx_flags_next  = verdict.flags;
            rx_len_next    = verdict.length;
        end
        else if (tx_out.refused)
        begin
            kind_next   = KIND_TX_REFUSE;
            tx_end_next = 1'b1;
        end
        else
        begin
            kind_next    = KIND_TX_BYTE;
            tx_byte_next = tx_out.data;
            tx_end_next  = tx_out.last;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg      <= kind_next;
            accepted_reg  <= accepted_next;
            rx_master_reg <= rx_master_next;
            rx_flags_reg  <= rx_flags_next;
            rx_len_reg    <= rx_len_next;
            tx_byte_reg   <= tx_byte_next;
            tx_end_reg    <= tx_end_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign accepted       = accepted_reg;
    assign rx_master      = rx_master_reg;
    assign rx_flags       = rx_flags_reg;
    assign rx_payload_len = rx_len_reg;
    assign tx_byte        = tx_byte_reg;
    assign tx_end         = tx_end_reg;

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("pending result overwritten");

    a_refuse_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_TX_REFUSE |-> tx_end_reg && tx_byte_reg == '0)
        else $error("refusal without end mark");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_VERDICT && !accepted_reg
            |-> rx_master_reg == '0 && rx_flags_reg == '0 && rx_len_reg == '0)
        else $error("rejected verdict carries header fields");

endmodule

`default_nettype wire
